// ----- rtl/mlp_pkg.sv -----
// Package for the fixed-point network inference block.
// Holds op codes, register indexes, default sizes and the sigmoid table.
// No dependencies.
package mlp_pkg;

	localparam int DEF_MAX_LAYERS  = 4;
	localparam int DEF_MAX_NEURONS = 32;
	localparam int DEF_FRAC_BITS   = 8;
	localparam int SIZE_REGS       = 4;
	localparam int CMD_FIFO_DEPTH  = 4;

	// input op codes
	localparam logic [1:0] OP_WEIGHT = 2'd0;
	localparam logic [1:0] OP_BIAS   = 2'd1;
	localparam logic [1:0] OP_ACT    = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_LAYER_COUNT = 3'd0;
	localparam logic [2:0] REG_SIZE0       = 3'd1;
	localparam logic [2:0] REG_SIZE1       = 3'd2;
	localparam logic [2:0] REG_SIZE2       = 3'd3;
	localparam logic [2:0] REG_SIZE3       = 3'd4;

	// what one queued command does
	typedef struct packed {
		logic wr_w;
		logic wr_b;
		logic wr_a;
		logic start;
	} cmd_flags_t;

	localparam int CMD_FLAGS_W = $bits(cmd_flags_t);

	// sigmoid in Q.8 at the left edge of each 0.25 step over [-8,8)
	localparam logic [8:0] SIG_LUT [64] = '{
		9'd0,   9'd0,   9'd0,   9'd0,   9'd0,   9'd0,   9'd0,   9'd0,
		9'd1,   9'd1,   9'd1,   9'd1,   9'd2,   9'd2,   9'd3,   9'd4,
		9'd5,   9'd6,   9'd8,   9'd10,  9'd12,  9'd15,  9'd19,  9'd24,
		9'd31,  9'd38,  9'd47,  9'd57,  9'd69,  9'd82,  9'd97,  9'd112,
		9'd128, 9'd144, 9'd159, 9'd174, 9'd187, 9'd199, 9'd209, 9'd218,
		9'd225, 9'd232, 9'd237, 9'd241, 9'd244, 9'd246, 9'd248, 9'd250,
		9'd251, 9'd252, 9'd253, 9'd254, 9'd254, 9'd255, 9'd255, 9'd255,
		9'd255, 9'd256, 9'd256, 9'd256, 9'd256, 9'd256, 9'd256, 9'd256
	};

endpackage

// ----- rtl/mlp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mlp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/mlp_cmd_fifo.sv -----
// Short command queue between the intake front and the compute engine.
// No dependencies.
module mlp_cmd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	parameter int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             fifo_full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             fifo_empty
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [PW:0]      count_q;

	assign fifo_full  = (int'(count_q) == DEPTH);
	assign fifo_empty = (count_q == '0);
	assign rd_data    = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (int'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (int'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (!wr_en && rd_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ----- rtl/mlp_front.sv -----
// Intake front: accepts items, drops out-of-range loads (a start still goes through), builds queue commands.
// Depends on mlp_pkg.
module mlp_front #(
	parameter int MAX_LAYERS  = mlp_pkg::DEF_MAX_LAYERS,
	parameter int MAX_NEURONS = mlp_pkg::DEF_MAX_NEURONS,
	parameter int WA          = $clog2((MAX_LAYERS - 1) * MAX_NEURONS * MAX_NEURONS)
) (
	input  logic               push,
	output logic               full,
	input  logic [1:0]         op,
	input  logic [1:0]         layer_sel,
	input  logic [4:0]         dest_neuron,
	input  logic [4:0]         src_neuron,
	input  logic signed [15:0] sample_value,
	input  logic               last_input,
	input  logic               fifo_full,
	output logic               enq,
	output mlp_pkg::cmd_flags_t enq_flags,
	output logic [WA-1:0]      enq_addr,
	output logic signed [15:0] enq_value
);
	import mlp_pkg::*;

	localparam int WL = MAX_LAYERS - 1;

	logic lsel_ok, dst_ok, src_ok;

	assign lsel_ok = int'(layer_sel) < WL;
	assign dst_ok  = int'(dest_neuron) < MAX_NEURONS;
	assign src_ok  = int'(src_neuron) < MAX_NEURONS;

	// classify the item
	always_comb begin
		enq_flags = '0;
		enq_addr  = '0;
		case (op)
			OP_WEIGHT: begin
				enq_flags.wr_w = lsel_ok && dst_ok && src_ok;
				enq_addr = WA'((int'(layer_sel) * MAX_NEURONS + int'(dest_neuron))
					* MAX_NEURONS + int'(src_neuron));
			end
			OP_BIAS: begin
				enq_flags.wr_b = lsel_ok && dst_ok;
				enq_addr = WA'(int'(layer_sel) * MAX_NEURONS + int'(dest_neuron));
			end
			OP_ACT: begin
				enq_flags.wr_a  = dst_ok;
				enq_flags.start = last_input;
				enq_addr = WA'(dest_neuron);
			end
			default: begin
				enq_flags = '0;
			end
		endcase
	end

	assign full      = fifo_full;
	assign enq_value = sample_value;
	assign enq       = push && !fifo_full && (enq_flags != '0);

endmodule

// ----- rtl/mlp_engine.sv -----
// Compute back end: applies queued loads and runs layer-by-layer evaluation
// with one shared multiply-accumulate; holds the result register.
// Depends on mlp_pkg and mlp_ram.
module mlp_engine #(
	parameter int MAX_LAYERS  = mlp_pkg::DEF_MAX_LAYERS,
	parameter int MAX_NEURONS = mlp_pkg::DEF_MAX_NEURONS,
	parameter int FRAC_BITS   = mlp_pkg::DEF_FRAC_BITS,
	parameter int WA          = $clog2((MAX_LAYERS - 1) * MAX_NEURONS * MAX_NEURONS),
	parameter int CNT_W       = $clog2(MAX_NEURONS + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_pop,
	input  mlp_pkg::cmd_flags_t cmd_flags,
	input  logic [WA-1:0]       cmd_addr,
	input  logic signed [15:0]  cmd_value,
	input  logic [2:0]          layer_num,
	input  logic [mlp_pkg::SIZE_REGS-1:0][CNT_W-1:0] layer_size,
	output logic                out_valid,
	input  logic                out_pop,
	output logic [4:0]          out_neuron,
	output logic [8:0]          out_value,
	output logic                out_last
);
	import mlp_pkg::*;

	localparam int WL      = MAX_LAYERS - 1;
	localparam int W_DEPTH = WL * MAX_NEURONS * MAX_NEURONS;
	localparam int B_DEPTH = WL * MAX_NEURONS;
	localparam int BA      = $clog2(B_DEPTH);
	localparam int NIDX    = $clog2(MAX_NEURONS);
	localparam int LW      = $clog2(MAX_LAYERS);
	localparam int ACC_W   = 34 + NIDX;
	localparam int LIM     = 8 << FRAC_BITS;
	localparam int SH_L    = (FRAC_BITS >= 8) ? FRAC_BITS - 8 : 0;
	localparam int SH_R    = (FRAC_BITS < 8) ? 8 - FRAC_BITS : 0;
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(32768);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_BIAS = 8'b0000_0010,
		S_BLD  = 8'b0000_0100,
		S_RD   = 8'b0000_1000,
		S_MUL  = 8'b0001_0000,
		S_ACC  = 8'b0010_0000,
		S_SAT  = 8'b0100_0000,
		S_SIG  = 8'b1000_0000
	} state_t;

	state_t                    state_q;
	logic [LW-1:0]             l_q;
	logic [CNT_W-1:0]          i_q, j_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [31:0]        prod_q;
	logic signed [15:0]        sum_q;
	logic                      out_valid_q;
	logic [4:0]                out_neuron_q;
	logic [8:0]                out_value_q;
	logic                      out_last_q;

	logic [CNT_W-1:0]          nin, nout;
	logic                      last_layer, i_last, take;
	logic                      out_free, sig_adv, out_load;
	logic signed [15:0]        w_rd, b_rd, a_rd, b_act_rd, act_rd;
	logic [WA-1:0]             w_raddr;
	logic [BA-1:0]             b_raddr;
	logic                      a_we, b_we;
	logic [NIDX-1:0]           a_waddr;
	logic signed [15:0]        a_wdata;
	logic signed [ACC_W-1:0]   acc_shr;
	logic signed [15:0]        sum_sat;
	int                        sig_x;
	logic [5:0]                sig_idx;
	logic [8:0]                q8;
	logic [15:0]               scaled;

	// layer geometry
	assign nin        = layer_size[2'(l_q)];
	assign nout       = layer_size[2'(int'(l_q) + 1)];
	assign last_layer = int'(l_q) == int'(layer_num) - 2;
	assign i_last     = int'(i_q) + 1 == int'(nout);

	// handshakes with queue and result register
	assign take     = (state_q == S_IDLE) && cmd_valid;
	assign cmd_pop  = take;
	assign out_free = !out_valid_q || out_pop;
	assign sig_adv  = (state_q == S_SIG) && (!last_layer || out_free);
	assign out_load = sig_adv && last_layer;

	// storage addressing; every layer, the output layer too, writes its activations
	assign w_raddr = WA'((int'(l_q) * MAX_NEURONS + int'(i_q)) * MAX_NEURONS + int'(j_q));
	assign b_raddr = BA'(int'(l_q) * MAX_NEURONS + int'(i_q));
	assign a_we    = (take && cmd_flags.wr_a) || (sig_adv && l_q[0]);
	assign b_we    = sig_adv && !l_q[0];
	assign a_waddr = take ? cmd_addr[NIDX-1:0] : i_q[NIDX-1:0];
	assign a_wdata = take ? cmd_value : signed'(scaled);
	assign act_rd  = l_q[0] ? b_act_rd : a_rd;

	mlp_ram #(.WIDTH(16), .DEPTH(W_DEPTH)) u_weight_ram (
		.clk(clk), .we(take && cmd_flags.wr_w), .waddr(cmd_addr), .wdata(cmd_value),
		.raddr(w_raddr), .rdata(w_rd)
	);

	mlp_ram #(.WIDTH(16), .DEPTH(B_DEPTH)) u_bias_ram (
		.clk(clk), .we(take && cmd_flags.wr_b), .waddr(cmd_addr[BA-1:0]),
		.wdata(cmd_value), .raddr(b_raddr), .rdata(b_rd)
	);

	mlp_ram #(.WIDTH(16), .DEPTH(MAX_NEURONS)) u_act_a_ram (
		.clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
		.raddr(j_q[NIDX-1:0]), .rdata(a_rd)
	);

	mlp_ram #(.WIDTH(16), .DEPTH(MAX_NEURONS)) u_act_b_ram (
		.clk(clk), .we(b_we), .waddr(i_q[NIDX-1:0]), .wdata(signed'(scaled)),
		.raddr(j_q[NIDX-1:0]), .rdata(b_act_rd)
	);

	// floor back to Q8.8 and saturate
	always_comb begin
		acc_shr = acc_q >>> FRAC_BITS;
		if (acc_shr > SAT_HI) begin
			sum_sat = 16'sd32767;
		end else if (acc_shr < SAT_LO) begin
			sum_sat = -16'sd32768;
		end else begin
			sum_sat = acc_shr[15:0];
		end
	end

	// clamped sigmoid lookup and rescale
	always_comb begin
		sig_x = int'(sum_q);
		if (sig_x < -LIM) begin
			sig_x = -LIM;
		end
		if (sig_x > LIM - 1) begin
			sig_x = LIM - 1;
		end
		sig_idx = 6'((sig_x + LIM) >>> (FRAC_BITS - 2));
		q8      = SIG_LUT[sig_idx];
		scaled  = (16'(q8) << SH_L) >> SH_R;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			l_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (take && cmd_flags.start) begin
						l_q     <= '0;
						i_q     <= '0;
						state_q <= S_BIAS;
					end
				end
				S_BIAS: state_q <= S_BLD;
				S_BLD: begin
					j_q     <= '0;
					state_q <= S_RD;
				end
				S_RD:  state_q <= S_MUL;
				S_MUL: state_q <= S_ACC;
				S_ACC: begin
					j_q     <= j_q + 1'b1;
					state_q <= (int'(j_q) + 1 == int'(nin)) ? S_SAT : S_RD;
				end
				S_SAT: state_q <= S_SIG;
				S_SIG: begin
					if (sig_adv) begin
						if (!i_last) begin
							i_q     <= i_q + 1'b1;
							state_q <= S_BIAS;
						end else if (last_layer) begin
							state_q <= S_IDLE;
						end else begin
							l_q     <= l_q + 1'b1;
							i_q     <= '0;
							state_q <= S_BIAS;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_BLD) begin
			acc_q <= ACC_W'(b_rd) <<< FRAC_BITS;
		end else if (state_q == S_ACC) begin
			acc_q <= acc_q + ACC_W'(prod_q);
		end
		if (state_q == S_MUL) begin
			prod_q <= w_rd * act_rd;
		end
		if (state_q == S_SAT) begin
			sum_q <= sum_sat;
		end
		if (out_load) begin
			out_neuron_q <= 5'(i_q);
			out_value_q  <= q8;
			out_last_q   <= i_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_neuron = out_neuron_q;
	assign out_value  = out_value_q;
	assign out_last   = out_last_q;

	// reads stay inside the source layer
	a_j_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD |-> int'(j_q) < int'(nin))
		else $error("weight read beyond source layer size");

	// the final output neuron ends the evaluation
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && i_last |=> state_q == S_IDLE)
		else $error("engine busy after final output neuron");

	// sigmoid step only follows saturation or a stall
	a_sig_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SIG |-> ($past(state_q) == S_SAT || $past(state_q) == S_SIG))
		else $error("sigmoid step entered out of order");

	// layer counter never passes the last weighted layer
	a_layer_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_BIAS |-> int'(l_q) <= int'(layer_num) - 2)
		else $error("layer counter out of range");

endmodule

// ----- rtl/mlp_forward_sigmoid.sv -----
// Fixed-point fully connected network inference with sigmoid lookup.
// Loads and input elements: one item per cycle, unless the queue is full, into a 4-entry command queue.
// Evaluation: per neuron a bias load, then read, multiply and accumulate per input,
// on one shared multiply-accumulate; each output neuron waits in one result register.
// Reset (async, low) clears control and sets registers to 2 layers of size 1.
// Weight, bias and activation memories are undefined until written.
module mlp_forward_sigmoid #(
	parameter int MAX_LAYERS  = mlp_pkg::DEF_MAX_LAYERS,
	parameter int MAX_NEURONS = mlp_pkg::DEF_MAX_NEURONS,
	parameter int FRAC_BITS   = mlp_pkg::DEF_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         op,
	input  logic [1:0]         layer_sel,
	input  logic [4:0]         dest_neuron,
	input  logic [4:0]         src_neuron,
	input  logic signed [15:0] sample_value,
	input  logic               last_input,
	output logic               empty,
	input  logic               pop,
	output logic [4:0]         out_neuron,
	output logic [8:0]         out_value,
	output logic               out_last,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [5:0]         cfg_data
);
	import mlp_pkg::*;

	localparam int WA     = $clog2((MAX_LAYERS - 1) * MAX_NEURONS * MAX_NEURONS);
	localparam int CNT_W  = $clog2(MAX_NEURONS + 1);
	localparam int TOP_L  = (MAX_LAYERS < SIZE_REGS) ? MAX_LAYERS : SIZE_REGS;
	localparam int CMD_W  = CMD_FLAGS_W + WA + 16;

	logic [2:0]               layer_count_q;
	logic [5:0]               size_q [SIZE_REGS];
	logic [2:0]               layer_num;
	logic [SIZE_REGS-1:0][CNT_W-1:0] layer_size;

	logic                     fifo_full, fifo_empty, enq, cmd_pop, out_valid;
	cmd_flags_t               enq_flags, cmd_flags;
	logic [WA-1:0]            enq_addr, cmd_addr;
	logic signed [15:0]       enq_value, cmd_value;
	logic [CMD_W-1:0]         fifo_rd;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layer_count_q <= 3'd2;
			for (int k = 0; k < SIZE_REGS; k++) begin
				size_q[k] <= 6'd1;
			end
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LAYER_COUNT: layer_count_q <= cfg_data[2:0];
				REG_SIZE0:       size_q[0] <= cfg_data;
				REG_SIZE1:       size_q[1] <= cfg_data;
				REG_SIZE2:       size_q[2] <= cfg_data;
				REG_SIZE3:       size_q[3] <= cfg_data;
				default:         ;
			endcase
		end
	end

	// effective layer count and sizes
	always_comb begin
		if (int'(layer_count_q) < 2) begin
			layer_num = 3'd2;
		end else if (int'(layer_count_q) > TOP_L) begin
			layer_num = 3'(TOP_L);
		end else begin
			layer_num = layer_count_q;
		end
		for (int k = 0; k < SIZE_REGS; k++) begin
			if (size_q[k] == '0) begin
				layer_size[k] = CNT_W'(1);
			end else if (int'(size_q[k]) > MAX_NEURONS) begin
				layer_size[k] = CNT_W'(MAX_NEURONS);
			end else begin
				layer_size[k] = CNT_W'(size_q[k]);
			end
		end
	end

	mlp_front #(
		.MAX_LAYERS(MAX_LAYERS), .MAX_NEURONS(MAX_NEURONS), .WA(WA)
	) u_front (
		.push(push), .full(full), .op(op), .layer_sel(layer_sel),
		.dest_neuron(dest_neuron), .src_neuron(src_neuron),
		.sample_value(sample_value), .last_input(last_input),
		.fifo_full(fifo_full), .enq(enq), .enq_flags(enq_flags),
		.enq_addr(enq_addr), .enq_value(enq_value)
	);

	mlp_cmd_fifo #(.WIDTH(CMD_W), .DEPTH(CMD_FIFO_DEPTH)) u_cmd_fifo (
		.clk(clk), .arst_n(arst_n), .wr_en(enq),
		.wr_data({enq_flags, enq_addr, enq_value}), .fifo_full(fifo_full),
		.rd_en(cmd_pop), .rd_data(fifo_rd), .fifo_empty(fifo_empty)
	);

	assign {cmd_flags, cmd_addr, cmd_value} = fifo_rd;

	mlp_engine #(
		.MAX_LAYERS(MAX_LAYERS), .MAX_NEURONS(MAX_NEURONS), .FRAC_BITS(FRAC_BITS),
		.WA(WA), .CNT_W(CNT_W)
	) u_engine (
		.clk(clk), .arst_n(arst_n), .cmd_valid(!fifo_empty), .cmd_pop(cmd_pop),
		.cmd_flags(cmd_flags), .cmd_addr(cmd_addr), .cmd_value(cmd_value),
		.layer_num(layer_num), .layer_size(layer_size),
		.out_valid(out_valid), .out_pop(pop), .out_neuron(out_neuron),
		.out_value(out_value), .out_last(out_last)
	);

	assign empty = !out_valid;

endmodule

// ----- tb/mlp_forward_sigmoid_tb.sv -----
// Self-checking testbench for mlp_forward_sigmoid: directed table, then random loads and
// evaluations over several layer setups, checked against a built-in fixed-point predictor.
// Depends on mlp_pkg (op codes, register indexes, sigmoid table) and the RTL top.
module mlp_forward_sigmoid_tb;
	import mlp_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int NEUR = DEF_MAX_NEURONS;
	localparam int WL = DEF_MAX_LAYERS - 1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [1:0] op = '0;
	logic [1:0] layer_sel = '0;
	logic [4:0] dest_neuron = '0;
	logic [4:0] src_neuron = '0;
	logic signed [15:0] sample_value = '0;
	logic last_input = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic [4:0] out_neuron;
	logic [8:0] out_value;
	logic out_last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [5:0] cfg_data = '0;

	mlp_forward_sigmoid dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#(20 * 3_000_000);
		$display("mlp_forward_sigmoid regression: fail");
		$finish;
	end

	// expected output neurons, oldest first
	typedef struct {
		logic [4:0] neuron;
		logic [8:0] value;
		logic last;
	} neuron_out_t;
	neuron_out_t neuron_q[$];

	// network state mirror
	logic [2:0] m_count;
	logic [5:0] m_size[4];
	logic signed [15:0] w_mem[WL][NEUR][NEUR];
	logic signed [15:0] b_mem[WL][NEUR];
	logic signed [15:0] act_a[NEUR];
	logic signed [15:0] act_b[NEUR];
	bit w_ok[WL][NEUR][NEUR];
	bit b_ok[WL][NEUR];
	bit a_ok[NEUR];

	int errors = 0;
	int send_idle = 0;
	int recv_idle = 0;
	int hold_cnt = 0;

	function automatic int num_layers();
		int n;
		n = m_count;
		if (n < 2) n = 2;
		if (n > 4) n = 4;
		return n;
	endfunction

	function automatic int layer_width(int l);
		int n;
		n = m_size[l];
		if (n < 1) n = 1;
		if (n > NEUR) n = NEUR;
		return n;
	endfunction

	function automatic logic [8:0] sigmoid_lookup(longint s);
		if (s < -2048) s = -2048;
		if (s > 2047) s = 2047;
		return SIG_LUT[(s + 2048) >>> 6];
	endfunction

	// layer-by-layer forward pass; hidden results ping-pong between the two vectors
	function automatic void forward_pass();
		int nl;
		int nin;
		int nout;
		bit cur_b;
		longint acc;
		logic [8:0] q8[NEUR];
		neuron_out_t n_out;
		nl = num_layers();
		cur_b = 0;
		nout = 0;
		for (int l = 0; l < nl - 1; l++) begin
			nin = layer_width(l);
			nout = layer_width(l + 1);
			for (int i = 0; i < nout; i++) begin
				acc = longint'(b_mem[l][i]) * 256;
				for (int j = 0; j < nin; j++)
					acc += longint'(w_mem[l][i][j]) * longint'(cur_b ? act_b[j] : act_a[j]);
				acc = acc >>> 8;
				if (acc > 32767) acc = 32767;
				if (acc < -32768) acc = -32768;
				q8[i] = sigmoid_lookup(acc);
				if (cur_b) begin
					act_a[i] = 16'(q8[i]);
					a_ok[i] = 1;
				end else begin
					act_b[i] = 16'(q8[i]);
				end
			end
			cur_b = !cur_b;
		end
		for (int i = 0; i < nout; i++) begin
			n_out.neuron = 5'(i);
			n_out.value = q8[i];
			n_out.last = (i + 1 == nout);
			neuron_q = {neuron_q, n_out};
		end
	endfunction

	function automatic void apply_item(logic [1:0] o, logic [1:0] ls, logic [4:0] d,
			logic [4:0] s, logic signed [15:0] v, logic lst);
		case (o)
			OP_WEIGHT: begin
				if (ls < WL) begin
					w_mem[ls][d][s] = v;
					w_ok[ls][d][s] = 1;
				end
			end
			OP_BIAS: begin
				if (ls < WL) begin
					b_mem[ls][d] = v;
					b_ok[ls][d] = 1;
				end
			end
			OP_ACT: begin
				act_a[d] = v;
				a_ok[d] = 1;
				if (lst) forward_pass();
			end
			default: ;
		endcase
	endfunction

	// one item on the input side; mirror updated at the accepting edge
	task automatic send_item(logic [1:0] o, logic [1:0] ls, logic [4:0] d, logic [4:0] s,
			logic signed [15:0] v, logic lst);
		while ($urandom_range(0, 99) < send_idle) begin
			push = 1'b0;
			@(negedge clk);
		end
		op = o;
		layer_sel = ls;
		dest_neuron = d;
		src_neuron = s;
		sample_value = v;
		last_input = lst;
		push = 1'b1;
		do @(posedge clk); while (full);
		apply_item(o, ls, d, s, v, lst);
		@(negedge clk);
		push = 1'b0;
	endtask

	task automatic cfg_write(logic [2:0] idx, logic [5:0] data);
		@(negedge clk);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_LAYER_COUNT) m_count = data[2:0];
		else if (idx <= REG_SIZE3) m_size[idx - 1] = data;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic signed [15:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'($urandom);
			default: return 16'($urandom_range(0, 1023)) - 16'sd512;
		endcase
	endfunction

	// load whatever the next evaluation would read but was never written
	task automatic fill_missing();
		int nl;
		nl = num_layers();
		for (int l = 0; l < nl - 1; l++)
			for (int i = 0; i < layer_width(l + 1); i++) begin
				if (!b_ok[l][i]) send_item(OP_BIAS, 2'(l), 5'(i), 5'($urandom), rand_sample(), 0);
				for (int j = 0; j < layer_width(l); j++)
					if (!w_ok[l][i][j])
						send_item(OP_WEIGHT, 2'(l), 5'(i), 5'(j), rand_sample(), 1'($urandom));
			end
		for (int j = 0; j < layer_width(0); j++)
			if (!a_ok[j]) send_item(OP_ACT, 2'($urandom), 5'(j), 5'($urandom), rand_sample(), 0);
	endtask

	// mostly well-formed update-then-evaluate sequences, some noise
	task automatic random_items(int n);
		int l;
		int i;
		logic [1:0] o;
		logic lst;
		repeat (n) begin
			if ($urandom_range(0, 9) < 7) begin
				fill_missing();
				repeat ($urandom_range(0, 3)) begin
					l = $urandom_range(0, num_layers() - 2);
					i = $urandom_range(0, layer_width(l + 1) - 1);
					if ($urandom_range(0, 1))
						send_item(OP_BIAS, 2'(l), 5'(i), 5'($urandom), rand_sample(), 0);
					else
						send_item(OP_WEIGHT, 2'(l), 5'(i),
							5'($urandom_range(0, layer_width(l) - 1)), rand_sample(), 0);
				end
				repeat ($urandom_range(0, layer_width(0) - 1))
					send_item(OP_ACT, 2'($urandom), 5'($urandom_range(0, layer_width(0) - 1)),
						5'($urandom), rand_sample(), 0);
				send_item(OP_ACT, 2'($urandom), 5'($urandom_range(0, layer_width(0) - 1)),
					5'($urandom), rand_sample(), 1);
			end else begin
				o = 2'($urandom);
				lst = 1'($urandom);
				if (o == OP_ACT && lst) fill_missing();
				send_item(o, 2'($urandom), 5'($urandom), 5'($urandom), rand_sample(), lst);
			end
		end
	endtask

	// wait out all expected outputs plus the input queue and a pass in flight
	task automatic settle();
		wait (neuron_q.size() == 0 && hold_cnt == 0);
		repeat (60) @(posedge clk);
	endtask

	// output side: random pop, long hold-off on request
	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		neuron_out_t exp_n;
		if (arst_n && pop && !empty) begin
			if (neuron_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected output neuron %0d value %0d",
					out_neuron, out_value);
			end else begin
				exp_n = neuron_q.pop_front();
				if (exp_n.neuron !== out_neuron || exp_n.value !== out_value ||
						exp_n.last !== out_last) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp n=%0d v=%0d l=%0d got n=%0d v=%0d l=%0d",
							exp_n.neuron, exp_n.value, exp_n.last,
							out_neuron, out_value, out_last);
				end
			end
		end
	end

	typedef struct {
		logic [1:0] o;
		logic [1:0] ls;
		logic [4:0] d;
		logic [4:0] s;
		logic signed [15:0] v;
		logic lst;
		int known;
	} dir_row_t;

	// default setup: two layers of one neuron; known = -1 means predicted
	dir_row_t dir_tab[16] = '{
		'{OP_WEIGHT, 2'd0, 5'd0, 5'd0, 16'sh7fff, 1'b0, -1},
		'{OP_BIAS, 2'd0, 5'd0, 5'd0, 16'sh7fff, 1'b0, -1},
		'{OP_ACT, 2'd0, 5'd0, 5'd0, 16'sh7fff, 1'b1, 256},
		'{OP_ACT, 2'd0, 5'd0, 5'd0, 16'sh8000, 1'b1, 0},
		'{OP_WEIGHT, 2'd0, 5'd0, 5'd0, 16'sh0000, 1'b1, -1},
		'{OP_BIAS, 2'd0, 5'd0, 5'd0, 16'sh0000, 1'b1, -1},
		'{OP_ACT, 2'd0, 5'd0, 5'd0, 16'sh1234, 1'b1, 128},
		'{OP_UNUSED, 2'd3, 5'd31, 5'd31, 16'sh8000, 1'b1, -1},
		'{OP_WEIGHT, 2'd3, 5'd31, 5'd31, 16'sh7fff, 1'b0, -1},
		'{OP_BIAS, 2'd3, 5'd31, 5'd0, 16'sh7fff, 1'b0, -1},
		'{OP_WEIGHT, 2'd2, 5'd31, 5'd31, 16'sh8000, 1'b0, -1},
		'{OP_BIAS, 2'd2, 5'd31, 5'd31, 16'sh8000, 1'b0, -1},
		'{OP_WEIGHT, 2'd0, 5'd0, 5'd0, 16'sh0100, 1'b0, -1},
		'{OP_BIAS, 2'd0, 5'd0, 5'd0, 16'shff00, 1'b0, -1},
		'{OP_ACT, 2'd1, 5'd31, 5'd31, 16'sh7fff, 1'b1, -1},
		'{OP_ACT, 2'd0, 5'd0, 5'd0, 16'sh0100, 1'b1, 128}
	};

	// layer setups: count, sizes 0..3, random items
	int setups[6][6] = '{
		'{2, 1, 1, 1, 1, 8},
		'{3, 4, 3, 2, 1, 6},
		'{4, 2, 2, 3, 2, 6},
		'{1, 3, 2, 0, 0, 6},
		'{7, 0, 2, 0, 3, 6},
		'{2, 1, 63, 1, 1, 3}
	};

	initial begin
		m_count = 3'd2;
		foreach (m_size[k]) m_size[k] = 6'd1;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		send_idle = 10;
		recv_idle = 75;

		// directed rows
		foreach (dir_tab[r]) begin
			send_item(dir_tab[r].o, dir_tab[r].ls, dir_tab[r].d, dir_tab[r].s,
				dir_tab[r].v, dir_tab[r].lst);
			if (dir_tab[r].known >= 0) neuron_q[$].value = 9'(dir_tab[r].known);
		end
		settle();

		foreach (setups[p]) begin
			if (p == 2) begin
				send_idle = 75;
				recv_idle = 10;
			end else if (p == 4) begin
				send_idle = 0;
				recv_idle = 0;
			end
			cfg_write(REG_LAYER_COUNT, 6'(setups[p][0]));
			cfg_write(REG_SIZE0, 6'(setups[p][1]));
			cfg_write(REG_SIZE1, 6'(setups[p][2]));
			cfg_write(REG_SIZE2, 6'(setups[p][3]));
			cfg_write(REG_SIZE3, 6'(setups[p][4]));
			cfg_write(3'($urandom_range(REG_SIZE3 + 1, 7)), 6'($urandom));
			// output held back so the block backs up and stalls intake
			if (p == 1) hold_cnt = 400;
			fill_missing();
			random_items(setups[p][5]);
			settle();
		end

		if (errors == 0)
			$display("mlp_forward_sigmoid regression: pass");
		else
			$display("mlp_forward_sigmoid regression: fail");
		$finish;
	end

endmodule
